FILE: rtl/ldr_pkg.sv
package ldr_pkg;

  localparam int unsigned COORD_W     = 6;
  localparam int unsigned FRAC        = 8;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned DVD_W       = COORD_W + FRAC;
  localparam int unsigned STEP_W      = $clog2(DVD_W);
  localparam int unsigned SLOPE_W     = FRAC + 2;
  localparam int unsigned ACC_W       = COORD_W + FRAC + 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RASTER_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     RASTER_RESET      = CFG_W'(64);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } line_cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   inside_res;
    logic   last_pixel;
  } pixel_t;

  // one classified line segment, ready to walk
  typedef struct packed {
    coord_t                     major0;
    coord_t                     minor0;
    coord_t                     span;
    logic signed [SLOPE_W-1:0]  slope;
    logic                       swapped;
    logic                       degen;
    color_t                     color;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } front_state_e;

  typedef enum logic {
    WK_IDLE,
    WK_RUN
  } walk_state_e;

endpackage

FILE: rtl/ldr_front.sv
module ldr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ldr_pkg::line_cmd_t cmd_i,
  output logic               busy_o,
  input  ldr_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output ldr_pkg::seg_t      seg_o
);

  localparam logic [ldr_pkg::STEP_W-1:0] LAST_STEP = ldr_pkg::STEP_W'(ldr_pkg::DVD_W - 1);

  ldr_pkg::front_state_e state_q, state_d;

  ldr_pkg::coord_t              a1_q, b1_q, span_q, div_q, rem_q;
  logic [ldr_pkg::DVD_W-1:0]    quo_q;
  logic [ldr_pkg::STEP_W-1:0]   step_q;
  logic                         swapped_q, degen_q, neg_q;
  ldr_pkg::color_t              color_q;

  logic                         accept;
  logic [ldr_pkg::COORD_W:0]    dx, dy, adx_w, ady_w;
  ldr_pkg::coord_t              adx, ady, ma1, mb1, ma2, mb2, minor_abs;
  logic                         swap, order, degen;

  logic [ldr_pkg::COORD_W:0]    shifted, diff;
  logic                         ge;
  ldr_pkg::coord_t              rem_d;
  logic [ldr_pkg::SLOPE_W-1:0]  mag;

  // classification of the incoming command
  always_comb begin
    dx    = {1'b0, cmd_i.end_x} - {1'b0, cmd_i.start_x};
    dy    = {1'b0, cmd_i.end_y} - {1'b0, cmd_i.start_y};
    adx_w = dx[ldr_pkg::COORD_W] ? (~dx + 1'b1) : dx;
    ady_w = dy[ldr_pkg::COORD_W] ? (~dy + 1'b1) : dy;
    adx   = adx_w[ldr_pkg::COORD_W-1:0];
    ady   = ady_w[ldr_pkg::COORD_W-1:0];
    swap  = adx < ady;
    ma1   = swap ? cmd_i.start_y : cmd_i.start_x;
    mb1   = swap ? cmd_i.start_x : cmd_i.start_y;
    ma2   = swap ? cmd_i.end_y   : cmd_i.end_x;
    mb2   = swap ? cmd_i.end_x   : cmd_i.end_y;
    order = ma1 > ma2;
    minor_abs = swap ? adx : ady;
    degen = (cmd_i.start_x == cmd_i.end_x) && (cmd_i.start_y == cmd_i.end_y);
  end

  // one restoring division step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[ldr_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, div_q};
    ge      = shifted >= {1'b0, div_q};
    rem_d   = ge ? diff[ldr_pkg::COORD_W-1:0] : shifted[ldr_pkg::COORD_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldr_pkg::FE_IDLE: if (start_i) state_d = degen ? ldr_pkg::FE_PUSH : ldr_pkg::FE_DIV;
      ldr_pkg::FE_DIV:  if (step_q == LAST_STEP) state_d = ldr_pkg::FE_PUSH;
      ldr_pkg::FE_PUSH: if (!q_stat_i.full) state_d = ldr_pkg::FE_IDLE;
      default:          state_d = ldr_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != ldr_pkg::FE_IDLE);
    accept = (state_q == ldr_pkg::FE_IDLE) && start_i;
    push_o = (state_q == ldr_pkg::FE_PUSH) && !q_stat_i.full;
  end

  always_comb begin
    mag           = {1'b0, quo_q[ldr_pkg::SLOPE_W-2:0]};
    seg_o.major0  = a1_q;
    seg_o.minor0  = b1_q;
    seg_o.span    = span_q;
    seg_o.slope   = neg_q ? -mag : mag;
    seg_o.swapped = swapped_q;
    seg_o.degen   = degen_q;
    seg_o.color   = color_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldr_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a1_q      <= order ? ma2 : ma1;
      b1_q      <= order ? mb2 : mb1;
      span_q    <= swap ? ady : adx;
      div_q     <= swap ? ady : adx;
      swapped_q <= swap;
      degen_q   <= degen;
      neg_q     <= dx[ldr_pkg::COORD_W] ^ dy[ldr_pkg::COORD_W];
      color_q   <= cmd_i.line_color;
      quo_q     <= {minor_abs, ldr_pkg::FRAC'(0)};
      rem_q     <= '0;
      step_q    <= '0;
    end else if (state_q == ldr_pkg::FE_DIV) begin
      quo_q  <= {quo_q[ldr_pkg::DVD_W-2:0], ge};
      rem_q  <= rem_d;
      step_q <= step_q + 1'b1;
    end
  end

endmodule

FILE: rtl/ldr_queue.sv
module ldr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ldr_pkg::seg_t    seg_i,
  input  logic             pop_i,
  output ldr_pkg::seg_t    seg_o,
  output ldr_pkg::q_stat_t stat_o
);

  localparam logic [ldr_pkg::QPTR_W:0] FULL_CNT = (ldr_pkg::QPTR_W + 1)'(ldr_pkg::QUEUE_DEPTH);

  ldr_pkg::seg_t               mem_q [ldr_pkg::QUEUE_DEPTH];
  logic [ldr_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ldr_pkg::QPTR_W:0]    cnt_q;

  always_comb begin
    stat_o.full  = (cnt_q == FULL_CNT);
    stat_o.empty = (cnt_q == '0);
    seg_o        = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= seg_i;
  end

endmodule

FILE: rtl/ldr_walker.sv
module ldr_walker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ldr_pkg::seg_t    seg_i,
  input  ldr_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  input  ldr_pkg::cfg_t    width_i,
  input  ldr_pkg::cfg_t    height_i,
  output logic             pix_valid_o,
  output ldr_pkg::pixel_t  result_o
);

  ldr_pkg::walk_state_e state_q, state_d;

  ldr_pkg::coord_t                major_q, left_q;
  logic [ldr_pkg::ACC_W-1:0]      acc_q;
  logic signed [ldr_pkg::SLOPE_W-1:0] slope_q;
  logic                           swapped_q, degen_q;
  ldr_pkg::color_t                color_q;
  ldr_pkg::pixel_t                out_q, out_d;
  logic                           strobe_q, strobe_d;

  ldr_pkg::coord_t                minor, px, py;
  logic                           last;
  logic [ldr_pkg::ACC_W-1:0]      slope_ext;

  always_comb begin
    minor     = acc_q[ldr_pkg::FRAC +: ldr_pkg::COORD_W];
    px        = swapped_q ? minor : major_q;
    py        = swapped_q ? major_q : minor;
    last      = (left_q == '0);
    slope_ext = {{(ldr_pkg::ACC_W - ldr_pkg::SLOPE_W){slope_q[ldr_pkg::SLOPE_W-1]}}, slope_q};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldr_pkg::WK_IDLE: if (!q_stat_i.empty) state_d = ldr_pkg::WK_RUN;
      ldr_pkg::WK_RUN:  if (last) state_d = ldr_pkg::WK_IDLE;
      default:          state_d = ldr_pkg::WK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == ldr_pkg::WK_IDLE) && !q_stat_i.empty;
    strobe_d = (state_q == ldr_pkg::WK_RUN);
    if (degen_q) begin
      out_d = '{pixel_x: '0, pixel_y: '0, pixel_color: '0, inside_res: 1'b0,
                last_pixel: 1'b1};
    end else begin
      out_d.pixel_x     = px;
      out_d.pixel_y     = py;
      out_d.pixel_color = color_q;
      out_d.inside_res  = ({1'b0, px} < width_i) && ({1'b0, py} < height_i);
      out_d.last_pixel  = last;
    end
  end

  assign pix_valid_o = strobe_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ldr_pkg::WK_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      major_q   <= seg_i.major0;
      acc_q     <= {2'b00, seg_i.minor0, ldr_pkg::FRAC'(0)};
      left_q    <= seg_i.span;
      slope_q   <= seg_i.slope;
      swapped_q <= seg_i.swapped;
      degen_q   <= seg_i.degen;
      color_q   <= seg_i.color;
    end else if (state_q == ldr_pkg::WK_RUN) begin
      major_q <= major_q + 1'b1;
      acc_q   <= acc_q + slope_ext;
      left_q  <= left_q - 1'b1;
    end
    if (strobe_d) out_q <= out_d;
  end

endmodule

FILE: rtl/line_dda_rasterizer_top.sv
// Line rasterizer. A command is taken when start_i is high and busy_o is low.
// The front end classifies the line in the cycle it is taken. Unless both
// endpoints coincide, it then runs a one-bit-per-cycle slope divider. It then
// hands the segment to a two-entry queue. busy_o stays high from the accepting
// edge through the divider and the hand-off, and for as long as the queue is
// full, so a new command is taken only once the last segment has been handed
// off. The pixel walker loads a segment from the queue and then emits one
// pixel per cycle on pix_valid_o/result_o. Each result is shown for exactly
// one cycle and cannot be held off, so the receiver must take every strobe. A
// line whose endpoints coincide gives one result with inside_res clear and
// last_pixel set. Raster width and height are written through cfg_we_i while
// no command is in flight; the user must keep to this, as the block itself
// does not enforce it.
module line_dda_rasterizer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  ldr_pkg::line_cmd_t               cmd_i,
  input  logic                             cfg_we_i,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  ldr_pkg::cfg_t                    cfg_data_i,
  output logic                             pix_valid_o,
  output ldr_pkg::pixel_t                  result_o
);

  ldr_pkg::cfg_t    width_q, height_q;
  ldr_pkg::seg_t    front_seg, queue_seg;
  ldr_pkg::q_stat_t q_stat;
  logic             push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ldr_pkg::RASTER_RESET;
      height_q <= ldr_pkg::RASTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ldr_pkg::CFG_RASTER_WIDTH:  width_q  <= cfg_data_i;
        ldr_pkg::CFG_RASTER_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  ldr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .q_stat_i (q_stat),
    .push_o   (push),
    .seg_o    (front_seg)
  );

  ldr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .seg_i  (front_seg),
    .pop_i  (pop),
    .seg_o  (queue_seg),
    .stat_o (q_stat)
  );

  ldr_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (queue_seg),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .pix_valid_o (pix_valid_o),
    .result_o    (result_o)
  );

endmodule

FILE: rtl/ldr_checker.sv
module ldr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            pix_valid_o,
  input ldr_pkg::pixel_t result_o
);

  // an accepted transaction always occupies the front end for a while
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o not raised after an accepted command");

  // pixels of one line come out back to back
  a_line_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_o && !result_o.last_pixel) |=> pix_valid_o)
    else $error("gap inside a line");

  a_color_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_o && !result_o.last_pixel) |=> $stable(result_o.pixel_color))
    else $error("color changed within a line");

  // the walker passes through its idle state to load the next segment between lines
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_o && result_o.last_pixel) |=> !pix_valid_o)
    else $error("no gap after the last pixel of a line");

endmodule

bind line_dda_rasterizer_top ldr_checker u_ldr_checker (.*);

FILE: tb/sv/line_dda_checker.sv
`timescale 1ns / 100ps

module line_dda_checker
  import ldr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  line_cmd_t            cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  cfg_t                 cfg_data_i,
  input  logic                 pix_valid_i,
  input  pixel_t               pixel_i,
  output int                   err_cnt_o,
  output int                   pending_o
);

  cfg_t   width_q;
  cfg_t   height_q;
  pixel_t pixel_q[$];
  int     err_cnt;

  // Walk a line along its major axis and queue every pixel it should produce.
  function automatic void trace_line(line_cmd_t c);
    int     x1, y1, x2, y2;
    int     a1, b1, a2, b2;
    int     da, db, tmp, slope, acc, n;
    bit     steep;
    coord_t major, minor;
    pixel_t p;
    x1 = int'(c.start_x);
    y1 = int'(c.start_y);
    x2 = int'(c.end_x);
    y2 = int'(c.end_y);
    p = '0;
    if (x1 == x2 && y1 == y2) begin
      p.last_pixel = 1'b1;
      pixel_q.push_back(p);
      return;
    end
    da = x2 - x1;
    db = y2 - y1;
    steep = ((da < 0) ? -da : da) < ((db < 0) ? -db : db);
    if (steep) begin
      a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      tmp = da; da = db; db = tmp;
    end else begin
      a1 = x1; b1 = y1; a2 = x2; b2 = y2;
    end
    // walk upward; da and db keep their signs, so the ratio is unchanged
    if (a1 > a2) begin
      tmp = a1; a1 = a2; a2 = tmp;
      tmp = b1; b1 = b2; b2 = tmp;
    end
    slope = (db * (1 << FRAC)) / da;
    acc   = b1 * (1 << FRAC);
    n     = a2 - a1 + 1;
    for (int i = 0; i < n; i++) begin
      major = coord_t'(a1 + i);
      minor = (acc < 0) ? '0 : coord_t'(acc >> FRAC);
      p.pixel_x     = steep ? minor : major;
      p.pixel_y     = steep ? major : minor;
      p.pixel_color = c.line_color;
      p.inside_res  = (int'(p.pixel_x) < int'(width_q)) &&
                      (int'(p.pixel_y) < int'(height_q));
      p.last_pixel  = (i == n - 1);
      pixel_q.push_back(p);
      acc += slope;
    end
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      width_q  = RASTER_RESET;
      height_q = RASTER_RESET;
      pixel_q.delete();
      err_cnt  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RASTER_WIDTH:  width_q = cfg_data_i;
          CFG_RASTER_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      // a pixel never belongs to a transaction accepted on the same edge
      if (pix_valid_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none got %0h", $time, pixel_i);
          err_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (pixel_i.pixel_x !== want.pixel_x)
            report_field("pixel_x", 32'(want.pixel_x), 32'(pixel_i.pixel_x));
          if (pixel_i.pixel_y !== want.pixel_y)
            report_field("pixel_y", 32'(want.pixel_y), 32'(pixel_i.pixel_y));
          if (pixel_i.pixel_color !== want.pixel_color)
            report_field("pixel_color", want.pixel_color, pixel_i.pixel_color);
          if (pixel_i.inside_res !== want.inside_res)
            report_field("inside_res", 32'(want.inside_res), 32'(pixel_i.inside_res));
          if (pixel_i.last_pixel !== want.last_pixel)
            report_field("last_pixel", 32'(want.last_pixel), 32'(pixel_i.last_pixel));
        end
      end
      if (start_i && !busy_i) trace_line(cmd_i);
    end
    err_cnt_o <= err_cnt;
    pending_o <= pixel_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ldr_pkg::*;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  line_cmd_t            cmd      = '0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = CFG_RASTER_WIDTH;
  cfg_t                 cfg_data = '0;
  logic                 pix_valid;
  pixel_t               pixel;
  int                   err_cnt;
  int                   pending;

  always #6 clk_i = ~clk_i;

  line_dda_rasterizer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_valid_o(pix_valid),
    .result_o   (pixel)
  );

  line_dda_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_valid_i(pix_valid),
    .pixel_i    (pixel),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  // Issue one line transaction, with random gaps beforehand.
  task automatic send_line(line_cmd_t c, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      cmd   <= line_cmd_t'({$urandom, $urandom});
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_raster(cfg_t w, cfg_t h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RASTER_WIDTH;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx  <= CFG_RASTER_HEIGHT;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic line_cmd_t mk_line(int x1, int y1, int x2, int y2, logic [31:0] col);
    line_cmd_t c;
    c.start_x    = coord_t'(x1);
    c.start_y    = coord_t'(y1);
    c.end_x      = coord_t'(x2);
    c.end_y      = coord_t'(y2);
    c.line_color = col;
    return c;
  endfunction

  // Mix of shapes: coincident endpoints, axis-aligned, diagonal, short, arbitrary.
  function automatic line_cmd_t rand_line();
    line_cmd_t c;
    int        x, y, d;
    c = line_cmd_t'({$urandom, $urandom});
    x = $urandom_range(63);
    y = $urandom_range(63);
    case ($urandom_range(9))
      0: begin
        c.end_x = c.start_x;
        c.end_y = c.start_y;
      end
      1: c.end_y = c.start_y;
      2: c.end_x = c.start_x;
      3: begin
        d = $urandom_range(63 - ((x > y) ? x : y));
        c.start_x = coord_t'(x);
        c.start_y = coord_t'(y);
        c.end_x   = coord_t'(x + d);
        c.end_y   = coord_t'(y + d);
        if ($urandom_range(1)) c.end_y = coord_t'(y - ((d > y) ? y : d));
      end
      4, 5: begin
        c.start_x = coord_t'(x);
        c.start_y = coord_t'(y);
        c.end_x   = coord_t'((x < 4) ? x + $urandom_range(3) : x - $urandom_range(3));
        c.end_y   = coord_t'((y > 59) ? y - $urandom_range(3) : y + $urandom_range(3));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cfg_t raster_w[6];
    cfg_t raster_h[6];
    int   gap_pct;
    raster_w = '{7'd0, 7'd127, 7'd63, 7'd1, cfg_t'($urandom_range(127)), 7'd40};
    raster_h = '{7'd127, 7'd0, 7'd1, 7'd63, cfg_t'($urandom_range(127)), 7'd23};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_raster(7'd64, 7'd64);

    send_line(mk_line(0, 0, 63, 63, 32'h0000_0000), 31);
    send_line(mk_line(63, 63, 0, 0, 32'hFFFF_FFFF), 31);
    send_line(mk_line(0, 0, 63, 0, 32'hA5A5_A5A5), 31);
    send_line(mk_line(63, 0, 0, 0, 32'h5A5A_5A5A), 31);
    send_line(mk_line(0, 0, 0, 63, 32'h1234_5678), 31);
    send_line(mk_line(0, 63, 0, 0, 32'h8765_4321), 31);
    send_line(mk_line(0, 0, 0, 0, 32'hFFFF_FFFF), 31);
    send_line(mk_line(63, 63, 63, 63, 32'h0000_0000), 31);
    send_line(mk_line(63, 0, 0, 63, 32'hDEAD_BEEF), 31);
    send_line(mk_line(0, 63, 63, 0, 32'hCAFE_F00D), 31);
    send_line(mk_line(0, 63, 1, 0, 32'h0F0F_0F0F), 31);
    send_line(mk_line(0, 40, 63, 0, 32'hF0F0_F0F0), 31);
    send_line(mk_line(10, 20, 30, 27, $urandom), 31);
    // equal major and minor spans pick the x axis
    send_line(mk_line(5, 5, 2, 8, $urandom), 31);
    send_line(mk_line(7, 7, 8, 7, $urandom), 31);
    send_line(mk_line(7, 7, 7, 6, $urandom), 31);
    send_line(mk_line(0, 1, 63, 0, $urandom), 31);
    send_line(mk_line(62, 0, 63, 63, $urandom), 31);
    send_line(mk_line(33, 12, 3, 50, $urandom), 0);
    send_line(mk_line(20, 44, 21, 45, $urandom), 0);

    for (int s = 0; s < 6; s++) begin
      wait_idle();
      set_raster(raster_w[s], raster_h[s]);
      gap_pct = (s < 2) ? 31 : (s < 4) ? 66 : 0;
      repeat (58) send_line(rand_line(), gap_pct);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ldr_pkg.sv
rtl/ldr_front.sv
rtl/ldr_queue.sv
rtl/ldr_walker.sv
rtl/line_dda_rasterizer_top.sv
rtl/ldr_checker.sv
tb/sv/line_dda_checker.sv
tb/sv/tb_top.sv
